// ===== rtl/qdmr_pkg.sv =====
package qdmr_pkg;

	// field widths
	localparam int unsigned TapW   = 9;
	localparam int unsigned ProdW  = 2 * TapW;
	localparam int unsigned AccW   = 32;
	localparam int unsigned MultW  = 31;
	localparam int unsigned ShiftW = 5;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = MultW;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_MULTIPLIER    = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_LEFT_SHIFT    = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_RIGHT_SHIFT   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_OUTPUT_OFFSET = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CLAMP_LOW     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CLAMP_HIGH    = 3'd5;

	// configuration reset values
	localparam logic [MultW-1:0]  MULT_RESET       = 31'h4000_0000;
	localparam logic [ByteW-1:0]  CLAMP_HIGH_RESET = 8'hFF;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_MUL,
		ST_HIGH,
		ST_RND,
		ST_OUT
	} qdmr_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic tap;       // input transaction this cycle
		logic load_pre;  // bias add and left shift
		logic load_mul;  // wide product
		logic load_high; // rounding doubling high part
		logic load_rnd;  // rounding right shift and offset
		logic load_out;  // clamp into output register
	} qdmr_cmd_t;

endpackage

// ===== rtl/qdmr_datapath.sv =====
module qdmr_datapath
	import qdmr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  qdmr_cmd_t                 cmd,
	input  logic signed [TapW-1:0]    src_value,
	input  logic signed [TapW-1:0]    weight_value,
	input  logic signed [AccW-1:0]    bias,
	input  logic                      last,
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data,
	output logic [ByteW-1:0]          out_value
);

	// configuration registers
	logic [MultW-1:0]  mult_q;
	logic [ShiftW-1:0] lshift_q;
	logic [ShiftW-1:0] rshift_q;
	logic [ByteW-1:0]  offset_q;
	logic [ByteW-1:0]  clamp_lo_q;
	logic [ByteW-1:0]  clamp_hi_q;

	// datapath registers
	logic signed [AccW-1:0]   acc_q;
	logic signed [AccW-1:0]   base_q;
	logic signed [AccW-1:0]   bias_q;
	logic signed [AccW-1:0]   pre_q;
	logic signed [2*AccW-1:0] prod_q;
	logic signed [AccW-1:0]   high_q;
	logic signed [AccW:0]     scaled_q;
	logic [ByteW-1:0]         out_value_q;

	// combinational intermediates
	logic signed [ProdW-1:0]  tap_prod;
	logic signed [AccW-1:0]   tap_sum;
	logic [AccW-1:0]          pre_sum;
	logic signed [AccW-1:0]   mul_a;
	logic signed [AccW-1:0]   mul_b;
	logic signed [2*AccW-1:0] mul_p;
	logic signed [2*AccW-1:0] nudge;
	logic signed [2*AccW-1:0] nudged;
	logic signed [AccW-1:0]   high_d;
	logic [AccW-1:0]          rmask;
	logic [AccW-1:0]          rrem;
	logic [AccW-1:0]          rthr;
	logic signed [AccW-1:0]   rfloor;
	logic signed [AccW-1:0]   rounded;
	logic signed [AccW:0]     scaled_d;
	logic signed [AccW:0]     lo_ext;
	logic signed [AccW:0]     hi_ext;
	logic signed [AccW:0]     clamped;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q     <= MULT_RESET;
			lshift_q   <= '0;
			rshift_q   <= '0;
			offset_q   <= '0;
			clamp_lo_q <= '0;
			clamp_hi_q <= CLAMP_HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MULTIPLIER:    mult_q     <= cfg_data;
				REG_LEFT_SHIFT:    lshift_q   <= cfg_data[ShiftW-1:0];
				REG_RIGHT_SHIFT:   rshift_q   <= cfg_data[ShiftW-1:0];
				REG_OUTPUT_OFFSET: offset_q   <= cfg_data[ByteW-1:0];
				REG_CLAMP_LOW:     clamp_lo_q <= cfg_data[ByteW-1:0];
				REG_CLAMP_HIGH:    clamp_hi_q <= cfg_data[ByteW-1:0];
				default: ;
			endcase
		end
	end

	// tap multiply-accumulate
	assign tap_prod = src_value * weight_value;
	assign tap_sum  = acc_q + AccW'(tap_prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.tap) begin
			acc_q <= last ? '0 : tap_sum;
		end
	end

	// window total and bias captured on the last tap
	always_ff @(posedge clk) begin
		if (cmd.tap && last) begin
			base_q <= tap_sum;
			bias_q <= bias;
		end
	end

	// bias add then left shift, both wrap at 32 bits
	assign pre_sum = base_q + bias_q;

	// Q31 product, multiplier is never negative
	assign mul_a = pre_q;
	assign mul_b = {1'b0, mult_q};
	assign mul_p = mul_a * mul_b;

	// round to nearest on the doubled high part, divide truncates toward zero
	assign nudge  = prod_q[2*AccW-1] ? (64'sd1 - 64'sd1073741824) : 64'sd1073741824;
	assign nudged = prod_q + nudge;
	assign high_d = AccW'(nudged >>> (AccW - 1))
		+ AccW'(nudged[2*AccW-1] && (|nudged[AccW-2:0]));

	// rounding right shift, ties away from zero
	assign rmask   = (AccW'(1) << rshift_q) - AccW'(1);
	assign rrem    = high_q & rmask;
	assign rthr    = (rmask >> 1) + AccW'(high_q[AccW-1]);
	assign rfloor  = high_q >>> rshift_q;
	assign rounded = rfloor + AccW'(rrem > rthr);
	assign scaled_d = (AccW+1)'(rounded) + $signed({25'b0, offset_q});

	// clamp: lower bound first, upper bound wins when the bounds cross
	assign lo_ext = $signed({25'b0, clamp_lo_q});
	assign hi_ext = $signed({25'b0, clamp_hi_q});

	always_comb begin
		clamped = scaled_q;
		if (clamped < lo_ext) begin
			clamped = lo_ext;
		end
		if (clamped > hi_ext) begin
			clamped = hi_ext;
		end
	end

	// requantization sequence registers
	always_ff @(posedge clk) begin
		if (cmd.load_pre) begin
			pre_q <= pre_sum << lshift_q;
		end
		if (cmd.load_mul) begin
			prod_q <= mul_p;
		end
		if (cmd.load_high) begin
			high_q <= high_d;
		end
		if (cmd.load_rnd) begin
			scaled_q <= scaled_d;
		end
		if (cmd.load_out) begin
			out_value_q <= clamped[ByteW-1:0];
		end
	end

	assign out_value = out_value_q;

endmodule

// ===== rtl/qdmr_ctrl.sv =====
module qdmr_ctrl
	import qdmr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output qdmr_cmd_t cmd
);

	qdmr_state_t state_q;
	qdmr_state_t state_d;
	logic        out_valid_q;
	logic        out_free;
	logic        tap_fire;

	assign in_ready = (state_q == ST_IDLE);
	assign tap_fire = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tap_fire && last) begin
					state_d = ST_PRE;
				end
			end
			ST_PRE:  state_d = ST_MUL;
			ST_MUL:  state_d = ST_HIGH;
			ST_HIGH: state_d = ST_RND;
			ST_RND:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd           = '0;
		cmd.tap       = tap_fire;
		cmd.load_pre  = (state_q == ST_PRE);
		cmd.load_mul  = (state_q == ST_MUL);
		cmd.load_high = (state_q == ST_HIGH);
		cmd.load_rnd  = (state_q == ST_RND);
		cmd.load_out  = (state_q == ST_OUT) && out_free;
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_last_starts_requant: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_fire && last) |=> (state_q == ST_PRE))
		else $error("last tap did not start requantization");

	a_out_waits_for_room: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && !out_free) |=> (state_q == ST_OUT) && out_valid_q)
		else $error("result left the sequencer while output was occupied");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten before transaction");

	a_valid_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("output valid raised outside output state");
`endif

endmodule

// ===== rtl/quant_dwconv_mac_requant_unit.sv =====
// Channel        | Signals                                 | Transaction
// ---------------+-----------------------------------------+-----------------------------
// tap input      | in_valid/in_ready, src_value,           | in_valid & in_ready
//                | weight_value, bias, last                |
// result output  | out_valid/out_ready, out_value          | out_valid & out_ready
// configuration  | cfg_we, cfg_index, cfg_data             | cfg_we (no wait, no read-back)
//
// A tap that is not last is accumulated into a register; taps can stream every cycle while in_ready is high.
// A last tap runs a five-step requantization sequence (bias and shift, Q31 multiply,
// high part, rounding shift, clamp); in_ready is low during it. The final step waits
// only while a previous result is still unclaimed; taps of the next window are taken
// while a result waits.
// Reset is asynchronous active low; it clears the accumulator and loads config defaults.
module quant_dwconv_mac_requant_unit
	import qdmr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [TapW-1:0] src_value,
	input  logic signed [TapW-1:0] weight_value,
	input  logic signed [AccW-1:0] bias,
	input  logic                   last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ByteW-1:0]       out_value,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgDataW-1:0]    cfg_data
);

	qdmr_cmd_t cmd;

	qdmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last      (last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	qdmr_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.src_value    (src_value),
		.weight_value (weight_value),
		.bias         (bias),
		.last         (last),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_value    (out_value)
	);

endmodule

// ===== tb/qdmr_result_checker.sv =====
`timescale 1ns / 1ps

module qdmr_result_checker
	import qdmr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic signed [TapW-1:0] src_value,
	input  logic signed [TapW-1:0] weight_value,
	input  logic signed [AccW-1:0] bias,
	input  logic                   last,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [ByteW-1:0]       out_value,
	input  logic                   cfg_we,
	input  logic [CfgIdxW-1:0]     cfg_index,
	input  logic [CfgDataW-1:0]    cfg_data,
	output int                     error_count,
	output int                     bytes_pending
);

	localparam int MaxReports = 10;

	// mirrored configuration
	logic [MultW-1:0]  multiplier_q;
	logic [ShiftW-1:0] left_shift_q;
	logic [ShiftW-1:0] right_shift_q;
	logic [ByteW-1:0]  output_offset_q;
	logic [ByteW-1:0]  clamp_low_q;
	logic [ByteW-1:0]  clamp_high_q;

	// running window sum and bytes still owed by the block
	logic [AccW-1:0]        tap_sum;
	logic signed [AccW-1:0] tap_product;
	logic [ByteW-1:0]       want_byte;
	logic [ByteW-1:0]       expected_bytes[$];

	// bias, shift, Q31 high multiply, rounding shift, offset and clamp
	function automatic logic [ByteW-1:0] requantize(input logic [AccW-1:0] sum,
			input logic [AccW-1:0] bias_in);
		logic [AccW-1:0] pre;
		longint v, m, prod, nudge, mask, rem, thr, off, lo, hi;
		pre = (sum + bias_in) << left_shift_q;
		v = $signed(pre);
		m = multiplier_q;
		prod = v * m;
		nudge = (prod >= 0) ? 64'sd1073741824 : 64'sd1 - 64'sd1073741824;
		// signed division truncates toward zero
		v = (prod + nudge) / 64'sd2147483648;
		// round half away from zero
		mask = (64'sd1 <<< right_shift_q) - 64'sd1;
		rem = v & mask;
		thr = (mask >>> 1) + ((v < 0) ? 64'sd1 : 64'sd0);
		v = (v >>> right_shift_q) + ((rem > thr) ? 64'sd1 : 64'sd0);
		off = output_offset_q;
		lo = clamp_low_q;
		hi = clamp_high_q;
		v = v + off;
		// low bound first, so crossed bounds give the high one
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v[ByteW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multiplier_q    = MULT_RESET;
			left_shift_q    = '0;
			right_shift_q   = '0;
			output_offset_q = '0;
			clamp_low_q     = '0;
			clamp_high_q    = CLAMP_HIGH_RESET;
			tap_sum         = '0;
			expected_bytes.delete();
			bytes_pending   = 0;
			error_count     = 0;
		end else begin
			// result transaction against the oldest expected byte
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					error_count++;
					if (error_count <= MaxReports)
						$display("%0t: unexpected result, out_value %0d", $realtime,
							out_value);
				end else begin
					want_byte = expected_bytes.pop_front();
					if (out_value !== want_byte) begin
						error_count++;
						if (error_count <= MaxReports)
							$display("%0t: out_value mismatch, expected %0d, got %0d",
								$realtime, want_byte, out_value);
					end
				end
			end

			// tap transaction
			if (in_valid && in_ready) begin
				tap_product = src_value * weight_value;
				tap_sum = tap_sum + tap_product;
				if (last) begin
					expected_bytes.push_back(requantize(tap_sum, bias));
					tap_sum = '0;
				end
			end

			// register writes; spare indexes are ignored
			if (cfg_we) begin
				case (cfg_index)
					REG_MULTIPLIER:    multiplier_q    = cfg_data[MultW-1:0];
					REG_LEFT_SHIFT:    left_shift_q    = cfg_data[ShiftW-1:0];
					REG_RIGHT_SHIFT:   right_shift_q   = cfg_data[ShiftW-1:0];
					REG_OUTPUT_OFFSET: output_offset_q = cfg_data[ByteW-1:0];
					REG_CLAMP_LOW:     clamp_low_q     = cfg_data[ByteW-1:0];
					REG_CLAMP_HIGH:    clamp_high_q    = cfg_data[ByteW-1:0];
					default: ;
				endcase
			end

			bytes_pending = expected_bytes.size();
		end
	end

endmodule

// ===== tb/quant_dwconv_mac_requant_unit_test.sv =====
`timescale 1ns / 1ps

module quant_dwconv_mac_requant_unit_test;
	import qdmr_pkg::*;

	localparam int WatchdogLimit  = 1000;
	localparam int DrainCycles    = 10;
	localparam int PhaseItems     = 72;
	localparam int RandomPhases   = 9;
	localparam int LongWindowTaps = 40;

	// indexes past the register list
	localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

	localparam logic [MultW-1:0]         MULT_MAX = '1;
	localparam logic signed [TapW-1:0]   TAP_MAX  = 9'sd255;
	localparam logic signed [TapW-1:0]   TAP_MIN  = -9'sd255;
	localparam logic signed [AccW-1:0]   BIAS_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [AccW-1:0]   BIAS_MIN = 32'sh8000_0000;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [TapW-1:0] src_value;
	logic signed [TapW-1:0] weight_value;
	logic signed [AccW-1:0] bias;
	logic                   last;
	logic                   out_valid;
	logic                   out_ready;
	logic [ByteW-1:0]       out_value;
	logic                   cfg_we;
	logic [CfgIdxW-1:0]     cfg_index;
	logic [CfgDataW-1:0]    cfg_data;

	int error_count;
	int bytes_pending;
	int quiet_cycles = 0;
	bit in_idle_on   = 1'b1;
	bit out_stall_on = 1'b1;

	quant_dwconv_mac_requant_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.src_value   (src_value),
		.weight_value(weight_value),
		.bias        (bias),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_value   (out_value),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	qdmr_result_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.src_value    (src_value),
		.weight_value (weight_value),
		.bias         (bias),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_value    (out_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.error_count  (error_count),
		.bytes_pending(bytes_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side back-pressure in bursts
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (out_stall_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// one tap transaction; entered and left at a falling edge, valid left high
	task automatic send_tap(input logic signed [TapW-1:0] s, input logic signed [TapW-1:0] w,
			input logic signed [AccW-1:0] b, input logic l);
		if (in_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		src_value    <= s;
		weight_value <= w;
		bias         <= b;
		last         <= l;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// drop valid, wait for every owed byte, then let the sequencer drain
	task automatic settle();
		in_valid <= 1'b0;
		while (bytes_pending != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [MultW-1:0] mult, input logic [ShiftW-1:0] lsh,
			input logic [ShiftW-1:0] rsh, input logic [ByteW-1:0] offs,
			input logic [ByteW-1:0] lo, input logic [ByteW-1:0] hi);
		write_reg(REG_MULTIPLIER, CfgDataW'(mult));
		write_reg(REG_LEFT_SHIFT, CfgDataW'(lsh));
		write_reg(REG_RIGHT_SHIFT, CfgDataW'(rsh));
		write_reg(REG_OUTPUT_OFFSET, CfgDataW'(offs));
		write_reg(REG_CLAMP_LOW, CfgDataW'(lo));
		write_reg(REG_CLAMP_HIGH, CfgDataW'(hi));
		// a write past the list must change nothing
		write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B,
			CfgDataW'($urandom));
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [TapW-1:0] rand_tap();
		int r;
		case ($urandom_range(0, 9))
			0: return TAP_MAX;
			1: return TAP_MIN;
			default: begin
				r = $urandom_range(0, 510) - 255;
				return r[TapW-1:0];
			end
		endcase
	endfunction

	function automatic logic signed [AccW-1:0] rand_bias();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return $urandom_range(0, 131072) - 65536;
	endfunction

	// random windows, mostly short, now and then long
	task automatic run_windows(input int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0)
				len = $urandom_range(9, 32);
			else
				len = $urandom_range(1, 8);
			for (int k = 1; k <= len; k++)
				send_tap(rand_tap(), rand_tap(), rand_bias(), k == len);
			sent += len;
		end
	endtask

	initial begin
		logic [ByteW-1:0] lo_pick;
		logic [ByteW-1:0] hi_pick;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		src_value    = '0;
		weight_value = '0;
		bias         = '0;
		last         = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed taps under reset configuration
		send_tap(TAP_MAX, TAP_MAX, '0, 1'b1);
		send_tap(TAP_MIN, TAP_MAX, '0, 1'b1);
		send_tap(TAP_MIN, TAP_MIN, BIAS_MIN, 1'b1);
		send_tap(TAP_MAX, TAP_MIN, BIAS_MAX, 1'b1);
		send_tap('0, '0, BIAS_MAX, 1'b1);
		send_tap('0, '0, BIAS_MIN, 1'b1);
		// rounding near zero, both signs
		send_tap(9'sd1, 9'sd1, 32'sd2, 1'b1);
		send_tap(-9'sd1, 9'sd1, -32'sd2, 1'b1);
		send_tap(9'sd1, 9'sd2, 32'sd0, 1'b1);
		send_tap(-9'sd3, 9'sd1, 32'sd0, 1'b1);
		// only the last tap's bias counts
		send_tap(TAP_MAX, TAP_MIN, BIAS_MAX, 1'b0);
		send_tap(9'sd100, 9'sd3, BIAS_MIN, 1'b0);
		send_tap(-9'sd7, 9'sd9, 32'sd300, 1'b1);
		// bias add wraps across the signed limit
		send_tap(TAP_MAX, TAP_MAX, BIAS_MAX, 1'b1);
		send_tap(TAP_MIN, TAP_MAX, BIAS_MIN, 1'b1);
		settle();

		// one longer window of full-scale taps, streamed back to back
		in_idle_on   = 1'b0;
		out_stall_on = 1'b0;
		for (int k = 0; k < LongWindowTaps; k++)
			send_tap(TAP_MAX, TAP_MAX, '0, 1'b0);
		send_tap(TAP_MAX, TAP_MAX, '0, 1'b1);
		settle();

		// random phases, each under its own configuration
		for (int p = 0; p < RandomPhases; p++) begin
			in_idle_on   = (p % 3) != 2;
			out_stall_on = (p % 4) != 3;
			if (p == RandomPhases - 1) begin
				in_idle_on   = 1'b0;
				out_stall_on = 1'b0;
			end
			case (p)
				0: set_config(MULT_MAX, 5'd0, 5'd0, 8'd0, 8'd0, 8'd255);
				1: set_config('0, 5'd31, 5'd31, 8'd255, 8'd255, 8'd0);
				2: set_config(MULT_MAX, 5'd31, 5'd0, 8'd128, 8'd0, 8'd255);
				default: begin
					if ($urandom_range(0, 5) == 0) begin
						lo_pick = ByteW'($urandom_range(0, 255));
						hi_pick = ByteW'($urandom_range(0, 255));
					end else begin
						lo_pick = ByteW'($urandom_range(0, 60));
						hi_pick = ByteW'($urandom_range(190, 255));
					end
					set_config(MultW'($urandom), ShiftW'($urandom_range(0, 10)),
						($urandom_range(0, 4) == 0) ? 5'd31 : 5'($urandom_range(0, 16)),
						ByteW'($urandom_range(0, 255)), lo_pick, hi_pick);
				end
			endcase
			run_windows(PhaseItems);
			settle();
		end

		if (error_count == 0 && bytes_pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
